### rtl/h4rd_pkg.sv
// ----------------------------------------------------------------------------
// h4rd_pkg
// types and constants shared by the h4 receive deframer
// ----------------------------------------------------------------------------
`default_nettype none

package h4rd_pkg;

  localparam int LEN_W = 17;

  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;
  localparam logic [7:0] TYPE_SCO   = 8'h03;

  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_ACL   = 2'd1;
  localparam logic [1:0] KIND_SCO   = 2'd2;

  localparam logic [LEN_W-1:0] HDR_EVENT = 17'd2;
  localparam logic [LEN_W-1:0] HDR_ACL   = 17'd4;
  localparam logic [LEN_W-1:0] HDR_SCO   = 17'd3;

  localparam logic [1:0] STATUS_DATA     = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [1:0] packet_kind;
    logic       frame_first;
    logic       frame_last;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic             in_frame;
    logic [1:0]       current_kind;
    logic             header_complete;
    logic [LEN_W-1:0] bytes_needed;
    logic [LEN_W-1:0] bytes_received;
    logic [7:0]       length_low_byte;
    logic             discarding;
  } frame_state_t;

  localparam frame_state_t FRAME_IDLE = '0;

endpackage

`default_nettype wire

### rtl/h4rd_step.sv
// ----------------------------------------------------------------------------
// h4rd_step
// next-state and result logic for one received byte
// ----------------------------------------------------------------------------
`default_nettype none

module h4rd_step import h4rd_pkg::*; #(
  parameter int MAX_FRAME = 1028
) (
  input  wire logic         enable,
  input  wire frame_state_t st,
  input  wire in_word_t     word,
  output frame_state_t      st_next,
  output logic              res_valid,
  output out_word_t         res
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] recv_inc;
    logic [LEN_W-1:0] header;
    logic [LEN_W-1:0] payload;
    logic             first;
    logic             last;

    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    idx       = st.bytes_received;
    recv_inc  = idx + 1'b1;
    header    = HDR_SCO;
    payload   = '0;
    first     = (idx == '0);
    last      = 1'b1;

    if (enable) begin
      if (st.discarding) begin
        if (word.chunk_last) begin
          st_next.discarding = 1'b0;
        end
      end else if (!st.in_frame) begin
        st_next = FRAME_IDLE;
        case (word.rx_byte)
          TYPE_EVENT: begin
            st_next.in_frame     = 1'b1;
            st_next.current_kind = KIND_EVENT;
            st_next.bytes_needed = HDR_EVENT;
          end
          TYPE_ACL: begin
            st_next.in_frame     = 1'b1;
            st_next.current_kind = KIND_ACL;
            st_next.bytes_needed = HDR_ACL;
          end
          TYPE_SCO: begin
            st_next.in_frame     = 1'b1;
            st_next.current_kind = KIND_SCO;
            st_next.bytes_needed = HDR_SCO;
          end
          default: begin
            st_next.discarding = !word.chunk_last;
            res_valid          = 1'b1;
            res.frame_byte     = word.rx_byte;
            res.packet_kind    = KIND_EVENT;
            res.status         = STATUS_UNKNOWN;
          end
        endcase
      end else begin
        st_next.bytes_received = recv_inc;
        if (idx == LEN_W'(2)) begin
          st_next.length_low_byte = word.rx_byte;
        end
        res_valid       = 1'b1;
        res.frame_byte  = word.rx_byte;
        res.packet_kind = st.current_kind;
        res.frame_first = first;
        res.status      = STATUS_DATA;
        if (recv_inc == st.bytes_needed) begin
          if (!st.header_complete) begin
            st_next.header_complete = 1'b1;
            case (st.current_kind)
              KIND_EVENT: begin
                header  = HDR_EVENT;
                payload = LEN_W'(word.rx_byte);
              end
              KIND_ACL: begin
                header  = HDR_ACL;
                payload = LEN_W'({word.rx_byte, st.length_low_byte});
              end
              default: begin
                header  = HDR_SCO;
                payload = LEN_W'(word.rx_byte);
              end
            endcase
            if (header + payload > MAX_LEN) begin
              st_next            = FRAME_IDLE;
              st_next.discarding = !word.chunk_last;
              res.frame_first    = 1'b0;
              res.status         = STATUS_OVERSIZE;
              last               = 1'b0;
            end else begin
              st_next.bytes_needed = st.bytes_needed + payload;
              if (payload != '0) begin
                last = 1'b0;
              end
            end
          end
          if (last) begin
            st_next = FRAME_IDLE;
          end
          res.frame_last = last;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/h4_receive_deframer.sv
// ----------------------------------------------------------------------------
// h4_receive_deframer
// splits an h4 byte stream into event, acl and sco frames
// ----------------------------------------------------------------------------
// One byte enters per cycle while in_stall is low; the byte is registered,
// the frame state and result word are computed in one pass and the result,
// if any, is held in an output register. Sustained rate is one byte per
// cycle while out_stall is low. Known type bytes and bytes dropped after an
// error produce no output word. Error words carry the offending byte with
// status set to unknown type or oversize frame.
`default_nettype none

module h4_receive_deframer import h4rd_pkg::*; #(
  parameter int MAX_FRAME = 1028
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_write,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic         receive_enable;
  logic         in_full;
  in_word_t     in_reg;
  frame_state_t st;
  frame_state_t st_next;
  logic         res_valid;
  out_word_t    res;
  logic         out_free;
  logic         process;

  assign out_free = !out_valid || !out_stall;
  assign process  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  h4rd_step #(
    .MAX_FRAME(MAX_FRAME)
  ) u_step (
    .enable    (receive_enable),
    .st        (st),
    .word      (in_reg),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enable <= 1'b0;
    end else if (cfg_write) begin
      receive_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FRAME_IDLE;
    end else if (process) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= process && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && process) begin
      out_word <= res;
    end
  end

endmodule

`default_nettype wire
